FILE: rtl/core/angle_pid_controller_defines.svh
// assertion macros for the angle pid controller
// expects clk and arst_n in the scope where a macro is used
`ifndef ANGLE_PID_CONTROLLER_DEFINES_SVH
`define ANGLE_PID_CONTROLLER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define APC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition never holds
`define APC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

FILE: rtl/core/apc_pkg.sv
// shared types and constants of the angle pid controller
// no dependencies
package apc_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned ERR_W = 17;
	localparam int unsigned DIFF_W = 18;
	localparam int unsigned GAIN_W = 24;
	localparam int unsigned DRIVE_W = 32;
	localparam int unsigned MAG_W = 31;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned LEVEL_W = 14;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic signed [ERR_W-1:0] HALF_TURN = 17'sd11520;
	localparam logic signed [ERR_W-1:0] FULL_TURN = 17'sd23040;
	localparam logic [MAG_W-1:0] DRIVE_LIMIT = 31'h7fff_ffff;

	typedef enum logic [1:0] {
		MODE_P   = 2'd0,
		MODE_PI  = 2'd1,
		MODE_PID = 2'd2,
		MODE_PD  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_PERIOD     = 3'd1,
		REG_PROP_GAIN  = 3'd2,
		REG_INT_GAIN   = 3'd3,
		REG_DERIV_GAIN = 3'd4,
		REG_MAX_DRIVE  = 3'd5,
		REG_MIN_DRIVE  = 3'd6,
		REG_SUM_LEVEL  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		mode_t                     mode;
		logic [PERIOD_W-1:0]       sample_period;
		logic signed [GAIN_W-1:0]  prop_gain;
		logic signed [GAIN_W-1:0]  integral_gain;
		logic signed [GAIN_W-1:0]  deriv_gain;
		logic [MAG_W-1:0]          max_drive;
		logic [MAG_W-1:0]          min_drive;
		logic [LEVEL_W-1:0]        sum_reset_level;
	} cfg_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] setpoint;
		logic signed [ANGLE_W-1:0] measurement;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: rtl/core/apc_if.sv
// sample and result channels of the angle pid controller
// depends on apc_pkg
interface apc_sample_if import apc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] setpoint;
	logic signed [ANGLE_W-1:0] measurement;

	modport source (output valid, setpoint, measurement, input ready);
	modport sink (input valid, setpoint, measurement, output ready);
endinterface

interface apc_result_if import apc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;

	modport source (output valid, drive, input ready);
	modport sink (input valid, drive, output ready);
endinterface

FILE: rtl/core/angle_pid_controller.sv
// angle pid controller top level: apb registers, front end, queue, back end
// a computed sample is written to the queue, then passes the registered back end stages to the drive output register
// throughput: one sample per cycle while the queue is not full, skipped and computed alike;
// the queue absorbs output stalls for four samples beyond the back end pipeline
// reset clears the tick counter, error sum, last error, queue and registers to defaults
`include "angle_pid_controller_defines.svh"

module angle_pid_controller import apc_pkg::*; #(
	parameter int SUM_WIDTH = 40,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	apc_sample_if.sink        sample,
	apc_result_if.source      result
);

	cfg_t   cfg;
	push_t  push;
	qstat_t qstat;
	item_t  head;
	logic   pop;

	apc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.sample_period (cfg.sample_period),
		.qstat         (qstat),
		.push          (push)
	);

	apc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	apc_back #(
		.SUM_WIDTH      (SUM_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	`APC_ASSERT_NEVER(a_queue_overflow, qstat.full && push.valid, "push into full queue")
	`APC_ASSERT_NOW(a_period_zero_push, sample.valid && sample.ready && cfg.sample_period == '0, push.valid, "sample not pushed with zero period")
	`APC_ASSERT_NEVER(a_drive_range, result.valid && result.drive[DRIVE_W-1] && result.drive[DRIVE_W-2:0] == '0, "drive outside symmetric range")

endmodule

FILE: rtl/core/apc_regs.sv
// apb configuration registers of the angle pid controller
// depends on apc_pkg
module apc_regs import apc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_PID;
			cfg_q.sample_period <= '0;
			cfg_q.prop_gain <= '0;
			cfg_q.integral_gain <= '0;
			cfg_q.deriv_gain <= '0;
			cfg_q.max_drive <= DRIVE_LIMIT;
			cfg_q.min_drive <= '0;
			cfg_q.sum_reset_level <= LEVEL_W'(HALF_TURN);
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:       cfg_q.mode <= mode_t'(pwdata[1:0]);
				REG_PERIOD:     cfg_q.sample_period <= pwdata[PERIOD_W-1:0];
				REG_PROP_GAIN:  cfg_q.prop_gain <= $signed(pwdata[GAIN_W-1:0]);
				REG_INT_GAIN:   cfg_q.integral_gain <= $signed(pwdata[GAIN_W-1:0]);
				REG_DERIV_GAIN: cfg_q.deriv_gain <= $signed(pwdata[GAIN_W-1:0]);
				REG_MAX_DRIVE:  cfg_q.max_drive <= pwdata[MAG_W-1:0];
				REG_MIN_DRIVE:  cfg_q.min_drive <= pwdata[MAG_W-1:0];
				REG_SUM_LEVEL:  cfg_q.sum_reset_level <= pwdata[LEVEL_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE:       prdata = {{(DATA_W-2){1'b0}}, cfg_q.mode};
			REG_PERIOD:     prdata = {{(DATA_W-PERIOD_W){1'b0}}, cfg_q.sample_period};
			REG_PROP_GAIN:  prdata = {{(DATA_W-GAIN_W){cfg_q.prop_gain[GAIN_W-1]}},
				cfg_q.prop_gain};
			REG_INT_GAIN:   prdata = {{(DATA_W-GAIN_W){cfg_q.integral_gain[GAIN_W-1]}},
				cfg_q.integral_gain};
			REG_DERIV_GAIN: prdata = {{(DATA_W-GAIN_W){cfg_q.deriv_gain[GAIN_W-1]}},
				cfg_q.deriv_gain};
			REG_MAX_DRIVE:  prdata = {{(DATA_W-MAG_W){1'b0}}, cfg_q.max_drive};
			REG_MIN_DRIVE:  prdata = {{(DATA_W-MAG_W){1'b0}}, cfg_q.min_drive};
			REG_SUM_LEVEL:  prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_q.sum_reset_level};
		endcase
	end

endmodule

FILE: rtl/core/apc_front.sv
// front end: accepts samples, runs the sample divider, pushes compute beats
// depends on apc_pkg and apc_if
module apc_front import apc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	apc_sample_if.sink          sample,
	input  logic [PERIOD_W-1:0] sample_period,
	input  qstat_t              qstat,
	output push_t               push
);

	logic [PERIOD_W-1:0] tick_q;
	logic                accept;
	logic                skip;

	assign sample.ready = !qstat.full;
	assign accept = sample.valid && sample.ready;
	assign skip = tick_q < sample_period;

	always_comb begin
		push.valid = accept && !skip;
		push.item.setpoint = sample.setpoint;
		push.item.measurement = sample.measurement;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (accept) begin
			if (skip) begin
				tick_q <= tick_q + 1'b1;
			end else begin
				tick_q <= '0;
			end
		end
	end

endmodule

FILE: rtl/core/apc_queue.sv
// small register queue between front and back end
// depends on apc_pkg
module apc_queue import apc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output item_t  head,
	output qstat_t qstat
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head = mem_q[rd_ptr_q];
	assign qstat.full = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/apc_back.sv
// back end: error wrap, integrator, pid terms, rounding and drive clamps
// depends on apc_pkg and apc_if
module apc_back import apc_pkg::*; #(
	parameter int SUM_WIDTH = 40,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  item_t  head,
	input  qstat_t qstat,
	output logic   pop,
	apc_result_if.source result
);

	localparam int LO_W = SUM_WIDTH / 2;
	localparam int HI_W = SUM_WIDTH - LO_W;
	localparam int P_W = GAIN_W + ERR_W;
	localparam int D_W = GAIN_W + DIFF_W;
	localparam int PD_W = D_W + 1;
	localparam int IL_W = GAIN_W + LO_W + 1;
	localparam int IH_W = GAIN_W + HI_W;
	localparam int I_W = GAIN_W + SUM_WIDTH;
	localparam int ACC_W = I_W + 2;
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		ACC_W'((64'd1 << GAIN_FRAC_BITS) >> 1);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		$signed({{(ACC_W-MAG_W){1'b0}}, DRIVE_LIMIT});
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;
	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic en;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_valid_q;

	// loop state
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [ERR_W-1:0]     last_err_q;

	// stage payloads
	logic signed [ERR_W-1:0]     err_s1;
	logic signed [ERR_W-1:0]     err_s2;
	logic signed [DIFF_W-1:0]    diff_s2;
	logic signed [SUM_WIDTH-1:0] sum_s2;
	logic signed [P_W-1:0]       p_s3;
	logic signed [D_W-1:0]       d_s3;
	logic signed [IL_W-1:0]      il_s3;
	logic signed [IH_W-1:0]      ih_s3;
	logic signed [I_W-1:0]       i_s4;
	logic signed [PD_W-1:0]      pd_s4;
	logic signed [ACC_W-1:0]     acc_s5;
	logic signed [DRIVE_W-1:0]   o_s6;
	logic signed [DRIVE_W-1:0]   o_s7;
	logic signed [DRIVE_W-1:0]   drive_q;

	// combinational next values
	logic signed [ERR_W-1:0]     err_c;
	logic signed [SUM_WIDTH-1:0] sum_c;
	logic signed [DIFF_W-1:0]    diff_c;
	logic                        clr_c;
	logic signed [I_W-1:0]       i_c;
	logic signed [PD_W-1:0]      pd_c;
	logic signed [ACC_W-1:0]     acc_c;
	logic signed [DRIVE_W-1:0]   o6_c;
	logic signed [DRIVE_W-1:0]   o7_c;
	logic signed [DRIVE_W-1:0]   drive_c;

	assign en = !out_valid_q || result.ready;
	assign pop = en && !qstat.empty;
	assign result.valid = out_valid_q;
	assign result.drive = drive_q;

	// error and wrap into half a turn
	always_comb begin
		logic signed [ERR_W-1:0] raw;
		raw = $signed({head.setpoint[ANGLE_W-1], head.setpoint})
			- $signed({head.measurement[ANGLE_W-1], head.measurement});
		if (raw > HALF_TURN) begin
			err_c = raw - FULL_TURN;
		end else if (raw < -HALF_TURN) begin
			err_c = raw + FULL_TURN;
		end else begin
			err_c = raw;
		end
	end

	// saturating integrator, difference, sum clear
	always_comb begin
		logic signed [SUM_WIDTH:0] ext;
		logic [ERR_W-1:0]          abs_err;
		ext = $signed({sum_q[SUM_WIDTH-1], sum_q})
			+ $signed({{(SUM_WIDTH+1-ERR_W){err_s1[ERR_W-1]}}, err_s1});
		if (ext[SUM_WIDTH] != ext[SUM_WIDTH-1]) begin
			sum_c = ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_c = ext[SUM_WIDTH-1:0];
		end
		diff_c = $signed({err_s1[ERR_W-1], err_s1})
			- $signed({last_err_q[ERR_W-1], last_err_q});
		abs_err = err_s1[ERR_W-1] ? ERR_W'(-err_s1) : ERR_W'(err_s1);
		clr_c = abs_err > {{(ERR_W-LEVEL_W){1'b0}}, cfg.sum_reset_level};
	end

	// integral product recombination and p plus d, with d only in the pd and pid modes
	always_comb begin
		logic use_d;
		use_d = (cfg.mode == MODE_PID) || (cfg.mode == MODE_PD);
		i_c = $signed({ih_s3, {LO_W{1'b0}}})
			+ $signed({{(I_W-IL_W){il_s3[IL_W-1]}}, il_s3});
		pd_c = $signed({{(PD_W-P_W){p_s3[P_W-1]}}, p_s3})
			+ (use_d ? $signed({d_s3[D_W-1], d_s3}) : PD_W'(0));
	end

	// mode select and rounding
	always_comb begin
		logic                    use_i;
		logic signed [ACC_W-1:0] sum_all;
		use_i = (cfg.mode == MODE_PI) || (cfg.mode == MODE_PID);
		sum_all = $signed({{(ACC_W-PD_W){pd_s4[PD_W-1]}}, pd_s4})
			+ (use_i ? $signed({{(ACC_W-I_W){i_s4[I_W-1]}}, i_s4}) : ACC_W'(0))
			+ ROUND_HALF;
		acc_c = sum_all >>> GAIN_FRAC_BITS;
	end

	// saturate to the drive range
	always_comb begin
		if (acc_s5 > SAT_HI) begin
			o6_c = DRIVE_W'(SAT_HI);
		end else if (acc_s5 < SAT_LO) begin
			o6_c = DRIVE_W'(SAT_LO);
		end else begin
			o6_c = acc_s5[DRIVE_W-1:0];
		end
	end

	// max clamp
	always_comb begin
		logic [DRIVE_W-1:0] t;
		logic [MAG_W-1:0]   m;
		t = o_s6[DRIVE_W-1] ? DRIVE_W'(-o_s6) : DRIVE_W'(o_s6);
		m = t[MAG_W-1:0];
		if (m >= cfg.max_drive) begin
			o7_c = o_s6[DRIVE_W-1] ? $signed(DRIVE_W'(0) - {1'b0, cfg.max_drive})
				: $signed({1'b0, cfg.max_drive});
		end else begin
			o7_c = o_s6;
		end
	end

	// min raise, zero counts as positive
	always_comb begin
		logic [DRIVE_W-1:0] t;
		logic [MAG_W-1:0]   m;
		t = o_s7[DRIVE_W-1] ? DRIVE_W'(-o_s7) : DRIVE_W'(o_s7);
		m = t[MAG_W-1:0];
		if (m <= cfg.min_drive) begin
			drive_c = o_s7[DRIVE_W-1] ? $signed(DRIVE_W'(0) - {1'b0, cfg.min_drive})
				: $signed({1'b0, cfg.min_drive});
		end else begin
			drive_c = o_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q <= '0;
			last_err_q <= '0;
		end else if (en) begin
			v_s1 <= !qstat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			out_valid_q <= v_s7;
			if (v_s1) begin
				sum_q <= clr_c ? '0 : sum_c;
				last_err_q <= err_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1 <= err_c;
			err_s2 <= err_s1;
			diff_s2 <= diff_c;
			sum_s2 <= sum_c;
			p_s3 <= cfg.prop_gain * err_s2;
			d_s3 <= cfg.deriv_gain * diff_s2;
			il_s3 <= cfg.integral_gain * $signed({1'b0, sum_s2[LO_W-1:0]});
			ih_s3 <= cfg.integral_gain * $signed(sum_s2[SUM_WIDTH-1:LO_W]);
			i_s4 <= i_c;
			pd_s4 <= pd_c;
			acc_s5 <= acc_c;
			o_s6 <= o6_c;
			o_s7 <= o7_c;
			drive_q <= drive_c;
		end
	end

endmodule
